// ----- design/sha256_pkg.sv -----
// Shared types, constants and round functions of the SHA-256 hash engine.
`default_nettype none

package sha256_pkg;

  typedef logic [7:0][31:0]  hash_t;
  typedef logic [15:0][31:0] sched_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_ZERO,
    S_LEN,
    S_ROUND,
    S_FEED,
    S_OUT
  } state_e;

  typedef struct packed {
    logic       init;
    logic       load_byte;
    logic [7:0] byte_val;
    logic       round;
  } core_ctrl_t;

  localparam logic [7:0]  PAD_MARK   = 8'h80;
  localparam logic [5:0]  LEN_START  = 6'd56;
  localparam logic [5:0]  LAST_BYTE  = 6'd63;
  localparam logic [5:0]  LAST_ROUND = 6'd63;
  localparam logic [2:0]  LAST_WORD  = 3'd7;
  localparam logic [63:0] BYTE_BITS  = 64'd8;

  localparam hash_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_s0(input logic [31:0] v);
    return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] v);
    return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] v);
    return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] v);
    return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'b0, v[31:10]};
  endfunction

endpackage

`default_nettype wire

// ----- design/sha256_core.sv -----
// SHA-256 round unit: working words, message window and one round per cycle.
`default_nettype none

module sha256_core (
  input  wire logic                   clk_i,
  input  wire sha256_pkg::core_ctrl_t ctrl_i,
  input  wire logic [5:0]             round_idx_i,
  input  wire sha256_pkg::hash_t      hash_i,
  output sha256_pkg::hash_t           work_o
);
  import sha256_pkg::*;

  hash_t       work_q, work_d;
  sched_t      win_q, win_d;
  logic [31:0] t1, t2, w_new, ch, maj;

  always_comb begin
    ch    = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
    maj   = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
    t1    = work_q[7] + big_s1(work_q[4]) + ch + ROUND_K[round_idx_i] + win_q[0];
    t2    = big_s0(work_q[0]) + maj;
    w_new = small_s1(win_q[14]) + win_q[9] + small_s0(win_q[1]) + win_q[0];

    work_d = work_q;
    if (ctrl_i.init) begin
      work_d = hash_i;
    end else if (ctrl_i.round) begin
      work_d[7] = work_q[6];
      work_d[6] = work_q[5];
      work_d[5] = work_q[4];
      work_d[4] = work_q[3] + t1;
      work_d[3] = work_q[2];
      work_d[2] = work_q[1];
      work_d[1] = work_q[0];
      work_d[0] = t1 + t2;
    end

    win_d = win_q;
    if (ctrl_i.load_byte) begin
      // bytes enter big-endian at word 15 and shift down; the first four end in word 0
      for (int i = 0; i < 15; i++) begin
        win_d[i] = {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_d[15] = {win_q[15][23:0], ctrl_i.byte_val};
    end else if (ctrl_i.round) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[15] = w_new;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    win_q  <= win_d;
  end

  assign work_o = work_q;

endmodule

`default_nettype wire

// ----- design/sha256_hash_engine.sv -----
// Top level of the SHA-256 hash engine: byte intake, padding, sequencing, digest out.
`default_nettype none

// Hashes a byte stream with SHA-256, one byte per input beat (tuser marks a beat that
// carries a byte, tlast ends the message) and returns the eight digest words, most
// significant first, as eight output beats. Every full 64-byte block then holds tready
// low while it is compressed: 64 rounds on the single round unit, then the feed-forward
// step. After the last beat the padding bytes go through the same byte path at one per
// cycle except while a block is compressed (9 to 72 bytes, with one or two block
// compressions), then the digest beats follow; tready stays low until the eighth
// digest beat is taken.
module sha256_hash_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] has_byte
  input  wire logic        s_axis_tlast_i,   // last
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]       m_axis_tuser_o,   // [2:0] word_index
  output logic             m_axis_tlast_o    // last_word
);
  import sha256_pkg::*;

  state_e      state_q, state_d, ret_q, ret_d;
  logic [5:0]  pos_q, pos_d;
  logic [5:0]  round_q, round_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic [63:0] bit_len_q, bit_len_d;
  hash_t       hash_q, hash_d;
  hash_t       work;
  core_ctrl_t  ctrl;
  logic [2:0]  len_sel;
  logic [7:0]  len_byte;
  logic        m_beat;

  assign m_beat   = m_axis_tvalid_o & m_axis_tready_i;
  assign len_sel  = 3'd7 - pos_q[2:0];
  assign len_byte = bit_len_q[{len_sel, 3'b000} +: 8];

  sha256_core u_core (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .round_idx_i (round_q),
    .hash_i      (hash_q),
    .work_o      (work)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      pos_q     <= '0;
      round_q   <= '0;
      out_idx_q <= '0;
      bit_len_q <= '0;
      hash_q    <= INIT_HASH;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      pos_q     <= pos_d;
      round_q   <= round_d;
      out_idx_q <= out_idx_d;
      bit_len_q <= bit_len_d;
      hash_q    <= hash_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    ret_d           = ret_q;
    pos_d           = pos_q;
    round_d         = round_q;
    out_idx_d       = out_idx_q;
    bit_len_d       = bit_len_q;
    hash_d          = hash_q;
    ctrl            = '0;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i[0]) begin
            ctrl.load_byte = 1'b1;
            ctrl.byte_val  = s_axis_tdata_i;
            ctrl.init      = (pos_q == LAST_BYTE);
            pos_d          = pos_q + 6'd1;
            bit_len_d      = bit_len_q + BYTE_BITS;
          end
          if (s_axis_tuser_i[0] && pos_q == LAST_BYTE) begin
            state_d = S_ROUND;
            ret_d   = s_axis_tlast_i ? S_MARK : S_IDLE;
          end else if (s_axis_tlast_i) begin
            state_d = S_MARK;
          end
        end
      end
      S_MARK, S_ZERO: begin
        ctrl.load_byte = 1'b1;
        ctrl.byte_val  = (state_q == S_MARK) ? PAD_MARK : 8'h00;
        ctrl.init      = (pos_q == LAST_BYTE);
        pos_d          = pos_q + 6'd1;
        if (pos_q == LAST_BYTE) begin
          state_d = S_ROUND;
          ret_d   = S_ZERO;
        end else if (pos_d == LEN_START) begin
          state_d = S_LEN;
        end else begin
          state_d = S_ZERO;
        end
      end
      S_LEN: begin
        ctrl.load_byte = 1'b1;
        ctrl.byte_val  = len_byte;
        ctrl.init      = (pos_q == LAST_BYTE);
        pos_d          = pos_q + 6'd1;
        if (pos_q == LAST_BYTE) begin
          state_d = S_ROUND;
          ret_d   = S_OUT;
        end
      end
      S_ROUND: begin
        ctrl.round = 1'b1;
        round_d    = round_q + 6'd1;
        if (round_q == LAST_ROUND) begin
          state_d = S_FEED;
        end
      end
      S_FEED: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + work[i];
        end
        state_d = ret_q;
      end
      S_OUT: begin
        m_axis_tvalid_o = 1'b1;
        if (m_axis_tready_i) begin
          out_idx_d = out_idx_q + 3'd1;
          if (out_idx_q == LAST_WORD) begin
            hash_d    = INIT_HASH;
            bit_len_d = '0;
            state_d   = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign m_axis_tdata_o = hash_q[out_idx_q];
  assign m_axis_tuser_o = out_idx_q;
  assign m_axis_tlast_o = (out_idx_q == LAST_WORD);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("input ready while digest beats pending");

  a_round_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_ROUND) |-> (round_q == 6'd0))
    else $error("round counter not cleared outside compression");

  a_len_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LEN) |-> (pos_q[5:3] == 3'b111))
    else $error("length bytes outside last eight block bytes");

  a_digest_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_beat && m_axis_tlast_o) |=> (s_axis_tready_o && pos_q == 6'd0 && bit_len_q == 64'd0))
    else $error("engine not reinitialized after digest");

endmodule

`default_nettype wire
